@@ rtl/lprd_pkg.sv @@
// Shared types, constants and helpers for the length-prefixed RC4 deframer.
package lprd_pkg;

	localparam int KEY_W       = 40;
	localparam int KEY_BYTES   = 5;
	localparam int KEY_IDX_W   = 3;
	localparam logic [KEY_IDX_W-1:0] KEY_LAST = KEY_IDX_W'(KEY_BYTES - 1);
	localparam int LEN_W       = 16;
	localparam int CFG_INDEX_W = 4;

	localparam int CMD_DEPTH_DEF = 4;
	localparam int OUT_DEPTH_DEF = 2;

	localparam logic [CFG_INDEX_W-1:0] REG_SESSION_KEY     = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_BODY_LENGTH = CFG_INDEX_W'(1);

	// command kinds handed from parser to cipher engine
	localparam logic [1:0] CMD_BODY  = 2'd0;
	localparam logic [1:0] CMD_EMPTY = 2'd1;
	localparam logic [1:0] CMD_ERROR = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic       last;
	} cmd_t;

	typedef struct packed {
		logic [7:0] plain_byte;
		logic       last_of_packet;
		logic       empty_packet;
		logic       length_error;
	} result_t;

	// key byte k of the session key; bytes beyond the register read as zero
	function automatic logic [7:0] key_byte(input logic [KEY_W-1:0] key,
	                                        input logic [KEY_IDX_W-1:0] idx);
		logic [63:0] ext;
		ext = 64'(key);
		return ext[idx*8 +: 8];
	endfunction

endpackage

@@ rtl/lprd_fifo.sv @@
// Small register FIFO used for the command queue and the result queue.
module lprd_fifo
	import lprd_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty,
	output logic             full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;

	function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign empty    = (count_q == '0);
	assign full     = (count_q == CW'(DEPTH));
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= bump(wr_ptr_q);
			if (pop)
				rd_ptr_q <= bump(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

endmodule

@@ rtl/lprd_front.sv @@
// Stream parser: tracks length header and body count, emits one command per result.
module lprd_front
	import lprd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       stream_byte,
	input  logic [LEN_W-1:0] max_len,
	input  logic             engine_busy,
	input  logic             q_full,
	output logic             q_push,
	output cmd_t             q_cmd
);

	localparam logic [1:0] PH_LOW  = 2'd0;
	localparam logic [1:0] PH_HIGH = 2'd1;
	localparam logic [1:0] PH_BODY = 2'd2;

	logic [1:0]       phase_q;
	logic [7:0]       len_lo_q;
	logic [LEN_W-1:0] remain_q;
	logic             halted_q;

	logic             accept;
	logic [LEN_W-1:0] hdr_len;
	logic             too_long;
	logic             body_last;

	assign in_stall  = q_full || engine_busy;
	assign accept    = in_valid && !in_stall;
	assign hdr_len   = {stream_byte, len_lo_q};
	assign too_long  = (hdr_len > max_len);
	assign body_last = (remain_q == LEN_W'(1));

	always_comb begin
		q_push = 1'b0;
		q_cmd  = '{kind: CMD_BODY, data: stream_byte, last: body_last};
		if (accept && !halted_q) begin
			unique case (phase_q)
				PH_HIGH: begin
					if (too_long) begin
						q_push = 1'b1;
						q_cmd  = '{kind: CMD_ERROR, data: 8'h00, last: 1'b0};
					end else if (hdr_len == '0) begin
						q_push = 1'b1;
						q_cmd  = '{kind: CMD_EMPTY, data: 8'h00, last: 1'b1};
					end
				end
				PH_BODY: q_push = 1'b1;
				default: q_push = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_LOW;
			len_lo_q <= '0;
			remain_q <= '0;
			halted_q <= 1'b0;
		end else if (accept && !halted_q) begin
			unique case (phase_q)
				PH_LOW: begin
					len_lo_q <= stream_byte;
					phase_q  <= PH_HIGH;
				end
				PH_HIGH: begin
					if (too_long) begin
						halted_q <= 1'b1;
						phase_q  <= PH_LOW;
					end else if (hdr_len == '0) begin
						phase_q <= PH_LOW;
					end else begin
						remain_q <= hdr_len;
						phase_q  <= PH_BODY;
					end
				end
				PH_BODY: begin
					remain_q <= remain_q - LEN_W'(1);
					if (body_last)
						phase_q <= PH_LOW;
				end
				default: phase_q <= PH_LOW;
			endcase
		end
	end

endmodule

@@ rtl/lprd_back.sv @@
// RC4 engine: key schedule, keystream generation over one state memory, result queue.
module lprd_back
	import lprd_pkg::*;
#(
	parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [KEY_W-1:0] key,
	input  logic             key_load,
	input  logic             cmd_valid,
	input  cmd_t             cmd,
	output logic             cmd_pop,
	output logic             busy,
	output logic             out_valid,
	input  logic             out_stall,
	output result_t          result
);

	localparam int RW = $clog2(OUT_DEPTH + 1);

	localparam logic [2:0] ST_SWEEP = 3'd0;
	localparam logic [2:0] ST_K0    = 3'd1;
	localparam logic [2:0] ST_K1    = 3'd2;
	localparam logic [2:0] ST_K2    = 3'd3;
	localparam logic [2:0] ST_K3    = 3'd4;
	localparam logic [2:0] ST_RUN   = 3'd5;
	localparam logic [2:0] ST_P1    = 3'd6;
	localparam logic [2:0] ST_P2    = 3'd7;

	logic [7:0] s_mem [256];
	logic [7:0] rdata_q;

	logic [2:0]           state_q;
	logic [7:0]           n_q, sn_q, i_q, j_q;
	logic [KEY_IDX_W-1:0] kidx_q;
	logic [RW-1:0]        resv_q;

	cmd_t       cmd_s1;
	logic       fwd_s1;
	logic [7:0] fwdv_s1;
	logic [7:0] si_s2;

	logic       valid_s3;
	cmd_t       cmd_s3;
	logic [7:0] si_s3;
	logic       ks_use_s3;
	logic [7:0] ks_fwd_s3;

	logic       issue, out_pop, out_full, out_empty, out_push;
	logic [7:0] raddr, waddr, wdata;
	logic       we;
	logic [7:0] i_next, si, j_next, ksa_j, k_addr;
	logic [7:0] ks;
	result_t    res_in;

	assign busy      = (state_q != ST_RUN) && (state_q != ST_P1) && (state_q != ST_P2);
	assign issue     = (state_q == ST_RUN) && cmd_valid && (resv_q != RW'(OUT_DEPTH));
	assign cmd_pop   = issue;
	assign out_valid = !out_empty;
	assign out_pop   = out_valid && !out_stall;

	assign i_next = i_q + 8'd1;
	assign si     = fwd_s1 ? fwdv_s1 : rdata_q;
	assign j_next = j_q + si;
	assign ksa_j  = j_q + rdata_q + key_byte(key, kidx_q);
	assign k_addr = si_s2 + rdata_q;
	assign ks     = ks_use_s3 ? ks_fwd_s3 : rdata_q;

	// read address and the single write port
	always_comb begin
		raddr = '0;
		we    = 1'b0;
		waddr = '0;
		wdata = '0;
		unique case (state_q)
			ST_SWEEP: begin
				we    = 1'b1;
				waddr = n_q;
				wdata = n_q;
			end
			ST_K0:  raddr = n_q;
			ST_K1:  raddr = ksa_j;
			ST_K2: begin
				we    = 1'b1;
				waddr = n_q;
				wdata = rdata_q;
			end
			ST_K3: begin
				we    = 1'b1;
				waddr = j_q;
				wdata = sn_q;
			end
			ST_RUN: raddr = i_next;
			ST_P1:  raddr = j_next;
			ST_P2: begin
				raddr = k_addr;
				we    = (cmd_s1.kind == CMD_BODY);
				waddr = i_q;
				wdata = rdata_q;
			end
			default: raddr = '0;
		endcase
		// second half of the swap lands in the cycle after P2
		if (valid_s3 && cmd_s3.kind == CMD_BODY) begin
			we    = 1'b1;
			waddr = j_q;
			wdata = si_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			s_mem[waddr] <= wdata;
		rdata_q <= s_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_SWEEP;
			n_q      <= '0;
			i_q      <= '0;
			j_q      <= '0;
			kidx_q   <= '0;
			valid_s3 <= 1'b0;
			resv_q   <= '0;
		end else begin
			resv_q   <= resv_q + RW'(issue) - RW'(out_pop);
			valid_s3 <= (state_q == ST_P2);
			if (key_load) begin
				state_q <= ST_SWEEP;
				n_q     <= '0;
				i_q     <= '0;
				j_q     <= '0;
				kidx_q  <= '0;
			end else begin
				unique case (state_q)
					ST_SWEEP: begin
						n_q <= n_q + 8'd1;
						if (n_q == 8'hFF) begin
							state_q <= ST_K0;
							j_q     <= '0;
							kidx_q  <= '0;
						end
					end
					ST_K0: state_q <= ST_K1;
					ST_K1: begin
						j_q     <= ksa_j;
						state_q <= ST_K2;
					end
					ST_K2: state_q <= ST_K3;
					ST_K3: begin
						n_q    <= n_q + 8'd1;
						kidx_q <= (kidx_q == KEY_LAST) ? '0 : kidx_q + KEY_IDX_W'(1);
						if (n_q == 8'hFF) begin
							state_q <= ST_RUN;
							i_q     <= '0;
							j_q     <= '0;
						end else begin
							state_q <= ST_K0;
						end
					end
					ST_RUN: begin
						if (issue) begin
							state_q <= ST_P1;
							if (cmd.kind == CMD_BODY)
								i_q <= i_next;
						end
					end
					ST_P1: begin
						state_q <= ST_P2;
						if (cmd_s1.kind == CMD_BODY)
							j_q <= j_next;
					end
					ST_P2:   state_q <= ST_RUN;
					default: state_q <= ST_SWEEP;
				endcase
			end
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (state_q == ST_K1)
			sn_q <= rdata_q;
		if (issue) begin
			cmd_s1  <= cmd;
			fwd_s1  <= valid_s3 && (cmd_s3.kind == CMD_BODY) && (i_next == j_q);
			fwdv_s1 <= si_s3;
		end
		if (state_q == ST_P1)
			si_s2 <= si;
		if (state_q == ST_P2) begin
			cmd_s3    <= cmd_s1;
			si_s3     <= si_s2;
			// S[j] is still stale and S[i] is written this cycle
			ks_use_s3 <= (k_addr == j_q) || (k_addr == i_q);
			ks_fwd_s3 <= (k_addr == j_q) ? si_s2 : rdata_q;
		end
	end

	assign out_push = valid_s3;

	always_comb begin
		case (cmd_s3.kind)
			CMD_BODY:  res_in = '{plain_byte: cmd_s3.data ^ ks, last_of_packet: cmd_s3.last,
			                      empty_packet: 1'b0, length_error: 1'b0};
			CMD_EMPTY: res_in = '{plain_byte: 8'h00, last_of_packet: 1'b1,
			                      empty_packet: 1'b1, length_error: 1'b0};
			default:   res_in = '{plain_byte: 8'h00, last_of_packet: 1'b0,
			                      empty_packet: 1'b0, length_error: 1'b1};
		endcase
	end

	lprd_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (out_push),
		.push_data (res_in),
		.pop       (out_pop),
		.pop_data  (result),
		.empty     (out_empty),
		.full      (out_full)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		resv_q <= RW'(OUT_DEPTH))
		else $error("result slots over-reserved");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> !out_full)
		else $error("result queue overflow");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_P2) |-> !valid_s3)
		else $error("write port conflict between swap halves");

	assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (!valid_s3 && !issue))
		else $error("keystream activity during key schedule");

endmodule

@@ rtl/length_prefixed_rc4_deframer.sv @@
// Top level of the length-prefixed RC4 deframer.
//
// Takes the received stream one byte per request on the in channel (in_valid /
// in_stall) and returns decrypted body bytes, empty-packet markers and a
// one-time length error on the out channel (out_valid / out_stall). Each packet
// opens with a little-endian 16-bit body length; a length above
// max_body_length yields one error result and every later byte is swallowed
// until reset. After reset and after every session_key write the engine fills
// its 256-entry permutation memory one entry at a time, then runs the key
// schedule through states K0 to K3 for each entry, with in_stall high. The
// keystream also restarts on a key write; parsing and halt state do not. The
// parser takes header bytes back to back while in_stall is low. Every result
// (body byte, empty marker or error) passes the RC4 engine states RUN, P1 and
// P2 in turn: the read of S[i], the dependent read of S[j] and the read of
// S[S[i]+S[j]] follow one another through the single registered read port of
// the permutation memory, with the second swap write overlapping the next
// request. A command queue between the parser and the engine lets header bytes
// run ahead, and a small result queue keeps the engine busy while out_stall is
// high. From P2 each result goes through the valid_s3 register into the result
// queue. cfg_ready is always high; out-of-range register indexes are ignored.
module length_prefixed_rc4_deframer
	import lprd_pkg::*;
#(
	parameter int CMD_DEPTH = CMD_DEPTH_DEF,
	parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// config write channel
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [KEY_W-1:0]       cfg_data,
	// stream in
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [7:0]             stream_byte,
	// results out
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [7:0]             plain_byte,
	output logic                   last_of_packet,
	output logic                   empty_packet,
	output logic                   length_error
);

	logic [KEY_W-1:0] key_q;
	logic [LEN_W-1:0] max_len_q;
	logic             cfg_wr, key_load;

	logic    q_push, q_pop, q_empty, q_full, engine_busy;
	cmd_t    q_cmd_in, q_cmd_out;
	result_t result;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign key_load  = cfg_wr && (cfg_index == REG_SESSION_KEY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q     <= '0;
			max_len_q <= '1;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_SESSION_KEY:     key_q     <= cfg_data;
				REG_MAX_BODY_LENGTH: max_len_q <= cfg_data[LEN_W-1:0];
				default:             ;
			endcase
		end
	end

	// parser: header tracking, body count, halt after a length error
	lprd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.stream_byte (stream_byte),
		.max_len     (max_len_q),
		.engine_busy (engine_busy),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_cmd       (q_cmd_in)
	);

	// decouples parsing from the keystream step
	lprd_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (CMD_DEPTH)
	) u_cmd_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_cmd_in),
		.pop       (q_pop),
		.pop_data  (q_cmd_out),
		.empty     (q_empty),
		.full      (q_full)
	);

	// key schedule, keystream, result queue
	lprd_back #(
		.OUT_DEPTH (OUT_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.key       (key_q),
		.key_load  (key_load),
		.cmd_valid (!q_empty),
		.cmd       (q_cmd_out),
		.cmd_pop   (q_pop),
		.busy      (engine_busy),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.result    (result)
	);

	assign plain_byte     = result.plain_byte;
	assign last_of_packet = result.last_of_packet;
	assign empty_packet   = result.empty_packet;
	assign length_error   = result.length_error;

endmodule

@@ sim/lprd_scoreboard_pkg.sv @@
// Scoreboard for the deframer: RC4 deframing predictor and queue of expected results.
`timescale 1ns / 100ps

package lprd_scoreboard_pkg;

	import lprd_pkg::*;

	typedef enum logic [1:0] {
		PARSE_LEN_LO,
		PARSE_LEN_HI,
		PARSE_BODY
	} parse_phase_e;

	class deframer_scoreboard;

		logic [KEY_W-1:0] session_key;
		logic [LEN_W-1:0] max_len;
		parse_phase_e     phase;
		logic [7:0]       len_low;
		logic [LEN_W-1:0] body_left;
		logic [7:0]       perm [256];
		logic [7:0]       ks_i;
		logic [7:0]       ks_j;
		bit               halted;
		result_t          pending_results [$];
		int               errors;

		function new();
			session_key = '0;
			max_len = '1;
			phase = PARSE_LEN_LO;
			len_low = '0;
			body_left = '0;
			halted = 1'b0;
			errors = 0;
			schedule_key();
		endfunction

		// RC4 key setup from the current session key
		function void schedule_key();
			logic [63:0] key_ext;
			logic [7:0]  j;
			logic [7:0]  t;
			logic [7:0]  kb;
			int          n;
			int          k;
			key_ext = 64'(session_key);
			j = '0;
			for (n = 0; n < 256; n++)
				perm[n] = 8'(n);
			for (n = 0; n < 256; n++) begin
				k = (n % KEY_BYTES) % 8;
				kb = key_ext[8*k +: 8];
				j = j + perm[n] + kb;
				t = perm[n];
				perm[n] = perm[j];
				perm[j] = t;
			end
			ks_i = '0;
			ks_j = '0;
		endfunction

		function logic [7:0] next_key_byte();
			logic [7:0] t;
			logic [7:0] idx;
			ks_i = ks_i + 8'd1;
			ks_j = ks_j + perm[ks_i];
			t = perm[ks_i];
			perm[ks_i] = perm[ks_j];
			perm[ks_j] = t;
			idx = perm[ks_i] + perm[ks_j];
			return perm[idx];
		endfunction

		// append one expected result at the tail
		function void expect_result(result_t r);
			pending_results = {pending_results, r};
		endfunction

		function void note_register_write(logic [CFG_INDEX_W-1:0] idx, logic [KEY_W-1:0] data);
			if (idx == REG_SESSION_KEY) begin
				session_key = data;
				schedule_key();
			end else if (idx == REG_MAX_BODY_LENGTH) begin
				max_len = data[LEN_W-1:0];
			end
		endfunction

		function void note_stream_byte(logic [7:0] b);
			logic [LEN_W-1:0] len;
			result_t          r;
			r = '0;
			if (halted)
				return;
			case (phase)
				PARSE_LEN_LO: begin
					len_low = b;
					phase = PARSE_LEN_HI;
				end
				PARSE_LEN_HI: begin
					len = {b, len_low};
					phase = PARSE_LEN_LO;
					if (len > max_len) begin
						halted = 1'b1;
						r.length_error = 1'b1;
						expect_result(r);
					end else if (len == '0) begin
						r.last_of_packet = 1'b1;
						r.empty_packet = 1'b1;
						expect_result(r);
					end else begin
						body_left = len;
						phase = PARSE_BODY;
					end
				end
				default: begin
					r.plain_byte = b ^ next_key_byte();
					body_left = body_left - 1'b1;
					r.last_of_packet = (body_left == '0);
					if (r.last_of_packet)
						phase = PARSE_LEN_LO;
					expect_result(r);
				end
			endcase
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				$error("unexpected result: plain_byte %02h last %0b empty %0b error %0b",
				       got.plain_byte, got.last_of_packet, got.empty_packet,
				       got.length_error);
				errors++;
				return;
			end
			want = pending_results[0];
			pending_results.delete(0);
			if (got.plain_byte !== want.plain_byte) begin
				$error("plain_byte: expected %02h, got %02h", want.plain_byte, got.plain_byte);
				errors++;
			end
			if (got.last_of_packet !== want.last_of_packet) begin
				$error("last_of_packet: expected %0b, got %0b",
				       want.last_of_packet, got.last_of_packet);
				errors++;
			end
			if (got.empty_packet !== want.empty_packet) begin
				$error("empty_packet: expected %0b, got %0b",
				       want.empty_packet, got.empty_packet);
				errors++;
			end
			if (got.length_error !== want.length_error) begin
				$error("length_error: expected %0b, got %0b",
				       want.length_error, got.length_error);
				errors++;
			end
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

	endclass

endpackage

@@ sim/tb_top.sv @@
// Testbench top: drives byte streams and register writes into the deframer, checks every result.
`timescale 1ns / 100ps

module tb_top;

	import lprd_pkg::*;
	import lprd_scoreboard_pkg::*;

	// header bytes ride a 4-deep queue and results still pass the engine
	// stages after reaching it: SETTLE_CYCLES covers anything still in flight
	// once the result queue is empty
	localparam int SETTLE_CYCLES   = 24;
	localparam int TAIL_CYCLES     = 40;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int RANDOM_ITEMS    = 1700;
	localparam int BIG_LEN         = 300;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [KEY_W-1:0]       cfg_data = '0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic [7:0]             stream_byte = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [7:0]             plain_byte;
	logic                   last_of_packet;
	logic                   empty_packet;
	logic                   length_error;

	deframer_scoreboard sb = new();

	// idling knobs, written only by the stimulus process
	bit tx_idle_on = 1'b0;
	bit rx_idle_on = 1'b0;
	// bumping this asks the receiver for one long hold-off
	int hold_off_req = 0;

	// bytes waiting to go out on the stream
	logic [7:0] tx_stream [$];

	always #5 clk = ~clk;

	length_prefixed_rc4_deframer uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.stream_byte    (stream_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.plain_byte     (plain_byte),
		.last_of_packet (last_of_packet),
		.empty_packet   (empty_packet),
		.length_error   (length_error)
	);

	// ------------------------------------------------------------------
	// Idle-length pickers: mostly short, a few long
	// ------------------------------------------------------------------
	function automatic int pick_gap();
		int r;
		if (!tx_idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic int pick_stall();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// ------------------------------------------------------------------
	// Receiver: checks each accepted result, drives out_stall.
	// Values are read at the edge, before this edge's updates land.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : rx_side
		result_t got;
		int      stall_left;
		int      hold_off_seen;
		if (out_valid === 1'b1 && out_stall == 1'b0) begin
			got.plain_byte     = plain_byte;
			got.last_of_packet = last_of_packet;
			got.empty_packet   = empty_packet;
			got.length_error   = length_error;
			sb.check_result(got);
		end
		// long hold-off: lets the command and result queues fill up and
		// pushes back on the stream side
		if (hold_off_seen != hold_off_req) begin
			hold_off_seen = hold_off_req;
			stall_left = HOLD_OFF_CYCLES;
		end
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (rx_idle_on && $urandom_range(0, 99) < 25) begin
			stall_left = pick_stall() - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// Stream side. Called at a clock edge; leaves in_valid high so
	// back-to-back bytes go out without a bubble.
	// ------------------------------------------------------------------
	task automatic send_stream_byte(input logic [7:0] b, input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			stream_byte <= 8'($urandom);
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		stream_byte <= b;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		// request accepted at this edge
		sb.note_stream_byte(b);
	endtask

	// stream queue helpers: add at the tail, take from the head
	function automatic void append_byte(input logic [7:0] b);
		tx_stream = {tx_stream, b};
	endfunction

	function automatic logic [7:0] take_byte();
		logic [7:0] b;
		b = tx_stream[0];
		tx_stream.delete(0);
		return b;
	endfunction

	// send queued bytes, holding back the last 'keep' of them
	task automatic send_queued(input int keep);
		while (tx_stream.size() > keep)
			send_stream_byte(take_byte(), pick_gap());
		in_valid <= 1'b0;
	endtask

	task automatic queue_packet(input int len);
		append_byte(len[7:0]);
		append_byte(len[15:8]);
		repeat (len) append_byte(8'($urandom));
	endtask

	// ------------------------------------------------------------------
	// Register writes; valid stays high across back-to-back writes
	// ------------------------------------------------------------------
	task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
	                              input logic [KEY_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (cfg_ready !== 1'b1)
			@(posedge clk);
		sb.note_register_write(idx, data);
	endtask

	task automatic end_config();
		cfg_valid <= 1'b0;
	endtask

	// wait until every expected result is back, then let in-flight
	// header bytes work through before touching registers
	task automatic wait_for_results();
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		logic [63:0] w;
		int          r;
		r = $urandom_range(0, 99);
		w = {$urandom, $urandom};
		if (r < 20)
			return '0;
		if (r < 40)
			return '1;
		return w[KEY_W-1:0];
	endfunction

	// new max length with junk in the unused upper data bits
	function automatic logic [KEY_W-1:0] pick_max_word();
		logic [63:0]      w;
		logic [LEN_W-1:0] m;
		int               r;
		r = $urandom_range(0, 99);
		w = {$urandom, $urandom};
		if (r < 15)
			m = '0;
		else if (r < 35)
			m = '1;
		else if (r < 70)
			m = LEN_W'($urandom_range(1, 16));
		else
			m = LEN_W'($urandom_range(0, 65535));
		return {w[KEY_W-1:LEN_W], m};
	endfunction

	task automatic randomize_config();
		bit                     wrote;
		logic [CFG_INDEX_W-1:0] junk_idx;
		wrote = 1'b0;
		if ($urandom_range(0, 1) == 0) begin
			write_register(REG_SESSION_KEY, pick_key());
			wrote = 1'b1;
		end
		if ($urandom_range(0, 2) == 0) begin
			write_register(REG_MAX_BODY_LENGTH, pick_max_word());
			wrote = 1'b1;
		end
		if ($urandom_range(0, 9) == 0) begin
			// index past the register map: must be dropped
			junk_idx = CFG_INDEX_W'($urandom_range(REG_MAX_BODY_LENGTH + 1,
			                                       (1 << CFG_INDEX_W) - 1));
			write_register(junk_idx, pick_key());
			wrote = 1'b1;
		end
		if (wrote)
			end_config();
	endtask

	// body length for a well-formed packet under the current maximum
	function automatic int pick_body_len();
		int r;
		int lim;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 0;
		if (r < 20 && sb.max_len <= 64)
			return sb.max_len;
		lim = (r < 90) ? 12 : 64;
		if (lim > sb.max_len)
			lim = sb.max_len;
		return $urandom_range(0, lim);
	endfunction

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin : stimulus
		int items_random;
		int phase_no;
		int npk;
		int len;
		int keep;
		int before_cnt;
		int m;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// --- directed: reset key, max 65535 ---
		// empty packet, one zero byte, two 0xFF bytes
		tx_stream = '{8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h02, 8'h00, 8'hFF, 8'hFF};
		send_queued(0);
		wait_for_results();

		// all-ones key, zero maximum, plus a write to an unmapped index
		write_register(REG_SESSION_KEY, '1);
		write_register(REG_MAX_BODY_LENGTH, '0);
		write_register(CFG_INDEX_W'((1 << CFG_INDEX_W) - 1), '1);
		end_config();
		// zero-length packet still passes with a zero maximum
		tx_stream = '{8'h00, 8'h00};
		send_queued(0);
		wait_for_results();

		// length equal to the maximum; key rewritten in mid-body, which
		// restarts the keystream but not the parse
		write_register(REG_MAX_BODY_LENGTH, KEY_W'(3));
		end_config();
		tx_stream = '{8'h03, 8'h00, 8'hFF, 8'h00, 8'h80};
		send_queued(2);
		wait_for_results();
		write_register(REG_SESSION_KEY, KEY_W'(40'h05_0403_0201));
		end_config();
		send_queued(0);
		wait_for_results();

		// --- long body with both length bytes set, no idling on either side ---
		write_register(REG_MAX_BODY_LENGTH, KEY_W'(16'hFFFF));
		end_config();
		send_stream_byte(8'(BIG_LEN), 0);
		send_stream_byte(8'(BIG_LEN >> 8), 0);
		repeat (BIG_LEN) send_stream_byte(8'($urandom), 0);
		in_valid <= 1'b0;
		wait_for_results();

		// --- random phases of well-formed packets ---
		items_random = 0;
		phase_no = 0;
		while (items_random < RANDOM_ITEMS) begin
			randomize_config();
			tx_idle_on = ($urandom_range(0, 3) != 0);
			rx_idle_on = ($urandom_range(0, 3) != 0);
			if (phase_no == 0 || $urandom_range(0, 9) == 0)
				hold_off_req++;
			npk = (phase_no == 0) ? 12 : $urandom_range(1, 12);
			len = 0;
			repeat (npk) begin
				len = pick_body_len();
				queue_packet(len);
			end
			// sometimes stop inside the last body; the rest goes out
			// first in the next phase, across any register writes
			keep = 0;
			if (len >= 2 && $urandom_range(0, 3) == 0)
				keep = $urandom_range(1, len - 1);
			before_cnt = tx_stream.size();
			send_queued(keep);
			items_random += before_cnt - keep;
			wait_for_results();
			phase_no++;
		end

		// --- length error, last since the block stays halted ---
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		send_queued(0);
		wait_for_results();
		m = $urandom_range(0, 300);
		write_register(REG_MAX_BODY_LENGTH, KEY_W'(m));
		end_config();
		queue_packet($urandom_range(0, m < 8 ? m : 8));
		len = $urandom_range(m + 1, 65535);
		append_byte(len[7:0]);
		append_byte(len[15:8]);
		// everything after the bad header is swallowed
		repeat (20) append_byte(8'($urandom));
		send_queued(0);
		wait_for_results();
		write_register(REG_SESSION_KEY, pick_key());
		end_config();
		repeat (10) append_byte(8'($urandom));
		send_queued(0);
		wait_for_results();

		// nothing more should come out
		rx_idle_on = 1'b0;
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

	// hard stop, several times the slowest legal run
	initial begin : watchdog
		#25_000_000;
		$display("tb_top: done, errors");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/lprd_pkg.sv
rtl/lprd_fifo.sv
rtl/lprd_front.sv
rtl/lprd_back.sv
rtl/length_prefixed_rc4_deframer.sv
sim/lprd_scoreboard_pkg.sv
sim/tb_top.sv
